>>> rtl/core/bfwq_pkg.sv
// ----------------------------------------------------------------------------
// bfwq_pkg
// Types, sizes and codes shared by the blocking FIFO with waiter queue.
// ----------------------------------------------------------------------------
package bfwq_pkg;

    localparam int ITEM_DEPTH   = 256;
    localparam int WAITER_DEPTH = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int ID_WIDTH     = 4;

    localparam int ITEM_AW   = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
    localparam int ITEM_CW   = $clog2(ITEM_DEPTH + 1);
    localparam int WAITER_AW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int WAITER_CW = $clog2(WAITER_DEPTH + 1);
    localparam int VISIT_W   = 32;

    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    localparam logic [1:0] REQ_ENQ   = 2'd0;
    localparam logic [1:0] REQ_DEQ   = 2'd1;
    localparam logic [1:0] REQ_TRY   = 2'd2;
    localparam logic [1:0] REQ_FLUSH = 2'd3;

    localparam logic [2:0] KIND_STORED   = 3'd0;
    localparam logic [2:0] KIND_HANDED   = 3'd1;
    localparam logic [2:0] KIND_DEQUEUED = 3'd2;
    localparam logic [2:0] KIND_EMPTY    = 3'd3;
    localparam logic [2:0] KIND_WAITING  = 3'd4;
    localparam logic [2:0] KIND_RELEASED = 3'd5;
    localparam logic [2:0] KIND_REJECTED = 3'd6;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_TRY,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [DATA_WIDTH-1:0] elem_data;
        logic [ID_WIDTH-1:0]   requester_id;
    } req_t;

    typedef struct packed {
        logic [2:0]            resp_kind;
        logic [ID_WIDTH-1:0]   target_id;
        logic [DATA_WIDTH-1:0] out_data;
        logic [ITEM_CW-1:0]    item_count;
        logic [WAITER_CW-1:0]  waiter_count;
        logic [VISIT_W-1:0]    visited_count;
        logic                  last;
    } rsp_t;

    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] data;
        logic [ID_WIDTH-1:0]   rid;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_port_t;

endpackage

>>> rtl/core/bfwq_ram.sv
// ----------------------------------------------------------------------------
// bfwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfwq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/bfwq_front.sv
// ----------------------------------------------------------------------------
// bfwq_front
// Request intake: decode each request and hold it in a short command queue.
// ----------------------------------------------------------------------------
module bfwq_front
    import bfwq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  req_t      request,
    output logic      busy,
    input  logic      pop,
    output cmd_port_t head
);

    cmd_t             q_mem [CQ_DEPTH];
    logic [CQ_AW-1:0] wr_ptr_reg;
    logic [CQ_AW-1:0] rd_ptr_reg;
    logic [CQ_CW-1:0] count_reg;
    logic             push;
    logic             do_pop;
    cmd_t             cmd_in;

    always_comb
    begin
        cmd_in.data = request.elem_data;
        cmd_in.rid  = request.requester_id;
        case (request.req_type)
            REQ_ENQ:   cmd_in.op = OP_ENQ;
            REQ_DEQ:   cmd_in.op = OP_DEQ;
            REQ_TRY:   cmd_in.op = OP_TRY;
            REQ_FLUSH: cmd_in.op = OP_FLUSH;
            default:   cmd_in.op = OP_FLUSH;
        endcase
    end

    assign busy   = (count_reg == CQ_CW'(CQ_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = q_mem[rd_ptr_reg];

endmodule

>>> rtl/core/bfwq_back.sv
// ----------------------------------------------------------------------------
// bfwq_back
// Execution engine: item and waiter queues, removal counter, result register.
// ----------------------------------------------------------------------------
module bfwq_back
    import bfwq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_port_t head,
    output logic      pop,
    output logic      result_valid,
    output rsp_t      result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH
    } state_t;

    state_t               state_reg,        state_next;
    logic [ITEM_AW-1:0]   item_head_reg,    item_head_next;
    logic [ITEM_AW-1:0]   item_tail_reg,    item_tail_next;
    logic [ITEM_CW-1:0]   item_level_reg,   item_level_next;
    logic [WAITER_AW-1:0] waiter_head_reg,  waiter_head_next;
    logic [WAITER_AW-1:0] waiter_tail_reg,  waiter_tail_next;
    logic [WAITER_CW-1:0] waiter_level_reg, waiter_level_next;
    logic [VISIT_W-1:0]   total_reg,        total_next;
    logic [ID_WIDTH-1:0]  rid_reg,          rid_next;
    logic                 valid_reg,        valid_next;
    rsp_t                 rsp_reg,          rsp_next;

    logic [ID_WIDTH-1:0]   waiter_mem [WAITER_DEPTH];
    logic                  w_we;
    logic                  r_we;
    logic                  r_re;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [ITEM_AW-1:0]    item_head_inc;
    logic [ITEM_AW-1:0]    item_tail_inc;
    logic [WAITER_AW-1:0]  waiter_head_inc;
    logic [WAITER_AW-1:0]  waiter_tail_inc;
    logic [ID_WIDTH-1:0]   waiter_front;

    bfwq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ITEM_DEPTH),
        .AW    (ITEM_AW)
    ) u_item_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (item_tail_reg),
        .wdata (head.cmd.data),
        .re    (r_re),
        .raddr (item_head_reg),
        .rdata (r_rdata)
    );

    assign item_head_inc   = (item_head_reg == ITEM_AW'(ITEM_DEPTH - 1)) ?
                             '0 : item_head_reg + 1'b1;
    assign item_tail_inc   = (item_tail_reg == ITEM_AW'(ITEM_DEPTH - 1)) ?
                             '0 : item_tail_reg + 1'b1;
    assign waiter_head_inc = (waiter_head_reg == WAITER_AW'(WAITER_DEPTH - 1)) ?
                             '0 : waiter_head_reg + 1'b1;
    assign waiter_tail_inc = (waiter_tail_reg == WAITER_AW'(WAITER_DEPTH - 1)) ?
                             '0 : waiter_tail_reg + 1'b1;
    assign waiter_front    = waiter_mem[waiter_head_reg];

    always_comb
    begin
        state_next        = state_reg;
        item_head_next    = item_head_reg;
        item_tail_next    = item_tail_reg;
        item_level_next   = item_level_reg;
        waiter_head_next  = waiter_head_reg;
        waiter_tail_next  = waiter_tail_reg;
        waiter_level_next = waiter_level_reg;
        total_next        = total_reg;
        rid_next          = rid_reg;
        valid_next        = 1'b0;
        rsp_next          = rsp_reg;
        pop               = 1'b0;
        w_we              = 1'b0;
        r_we              = 1'b0;
        r_re              = 1'b0;
        rsp_next.resp_kind = KIND_STORED;
        rsp_next.target_id = '0;
        rsp_next.out_data  = '0;
        rsp_next.last      = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    case (head.cmd.op)
                        OP_ENQ:
                        begin
                            if (waiter_level_reg != '0)
                            begin
                                waiter_head_next   = waiter_head_inc;
                                waiter_level_next  = waiter_level_reg - 1'b1;
                                total_next         = total_reg + 1'b1;
                                rsp_next.resp_kind = KIND_HANDED;
                                rsp_next.target_id = waiter_front;
                                rsp_next.out_data  = head.cmd.data;
                            end
                            else if (item_level_reg == ITEM_CW'(ITEM_DEPTH))
                            begin
                                rsp_next.resp_kind = KIND_REJECTED;
                            end
                            else
                            begin
                                r_we            = 1'b1;
                                item_tail_next  = item_tail_inc;
                                item_level_next = item_level_reg + 1'b1;
                            end
                        end
                        OP_DEQ, OP_TRY:
                        begin
                            rsp_next.target_id = head.cmd.rid;
                            if (item_level_reg != '0)
                            begin
                                r_re            = 1'b1;
                                item_head_next  = item_head_inc;
                                item_level_next = item_level_reg - 1'b1;
                                total_next      = total_reg + 1'b1;
                                rid_next        = head.cmd.rid;
                                valid_next      = 1'b0;
                                state_next      = ST_READ;
                            end
                            else if (head.cmd.op == OP_TRY)
                            begin
                                rsp_next.resp_kind = KIND_EMPTY;
                            end
                            else if (waiter_level_reg == WAITER_CW'(WAITER_DEPTH))
                            begin
                                rsp_next.resp_kind = KIND_REJECTED;
                            end
                            else
                            begin
                                w_we               = 1'b1;
                                waiter_tail_next   = waiter_tail_inc;
                                waiter_level_next  = waiter_level_reg + 1'b1;
                                rsp_next.resp_kind = KIND_WAITING;
                            end
                        end
                        OP_FLUSH:
                        begin
                            item_head_next  = '0;
                            item_tail_next  = '0;
                            item_level_next = '0;
                            if (waiter_level_reg == '0)
                            begin
                                waiter_head_next   = '0;
                                waiter_tail_next   = '0;
                                rsp_next.resp_kind = KIND_RELEASED;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                valid_next         = 1'b1;
                rsp_next.resp_kind = KIND_DEQUEUED;
                rsp_next.target_id = rid_reg;
                rsp_next.out_data  = r_rdata;
                state_next         = ST_IDLE;
            end
            ST_FLUSH:
            begin
                valid_next         = 1'b1;
                rsp_next.resp_kind = KIND_RELEASED;
                rsp_next.target_id = waiter_front;
                waiter_head_next   = waiter_head_inc;
                waiter_level_next  = waiter_level_reg - 1'b1;
                rsp_next.last      = (waiter_level_reg == WAITER_CW'(1));
                if (waiter_level_reg == WAITER_CW'(1))
                begin
                    waiter_head_next = '0;
                    waiter_tail_next = '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next.item_count    = item_level_next;
        rsp_next.waiter_count  = waiter_level_next;
        rsp_next.visited_count = total_next;
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            waiter_mem[waiter_tail_reg] <= head.cmd.rid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            item_head_reg    <= '0;
            item_tail_reg    <= '0;
            item_level_reg   <= '0;
            waiter_head_reg  <= '0;
            waiter_tail_reg  <= '0;
            waiter_level_reg <= '0;
            total_reg        <= '0;
            rid_reg          <= '0;
            valid_reg        <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            item_head_reg    <= item_head_next;
            item_tail_reg    <= item_tail_next;
            item_level_reg   <= item_level_next;
            waiter_head_reg  <= waiter_head_next;
            waiter_tail_reg  <= waiter_tail_next;
            waiter_level_reg <= waiter_level_next;
            total_reg        <= total_next;
            rid_reg          <= rid_next;
            valid_reg        <= valid_next;
            rsp_reg          <= rsp_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = rsp_reg;

endmodule

>>> rtl/core/blocking_fifo_with_waiter_queue.sv
// ----------------------------------------------------------------------------
// blocking_fifo_with_waiter_queue
// FIFO mailbox that hands items to waiting consumers or stores them.
//
//   channel   handshake              payload
//   request   start, busy            request  (req_t)
//   result    result_valid (strobe)  result   (rsp_t)
//
// A request enters a two-entry command queue and the engine takes one from
// it per cycle when idle. The results of enqueue, waiting, empty, rejected
// and waiter-free flush requests are registered and appear in the cycle after
// the engine takes them; a dequeue that finds an item first passes ST_READ
// (registered item RAM read), and a flush with waiters releases them in turn.
// busy is high while the command queue is full. Reset empties both queues
// and clears the removal count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module blocking_fifo_with_waiter_queue
    import bfwq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic result_valid,
    output rsp_t result
);

    cmd_port_t head;
    logic      pop;

    bfwq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .pop     (pop),
        .head    (head)
    );

    bfwq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

>>> rtl/core/bfwq_checker.sv
// ----------------------------------------------------------------------------
// bfwq_checker
// Port-level checks on the result stream of the mailbox.
// ----------------------------------------------------------------------------
module bfwq_checker
    import bfwq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input rsp_t result
);

    a_flush_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("release burst broken");

    a_release_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.resp_kind == KIND_RELEASED |-> result.item_count == '0)
        else $error("items left after flush");

    a_waiter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.waiter_count <= WAITER_CW'(WAITER_DEPTH))
        else $error("waiter count beyond depth");

    a_stored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.resp_kind == KIND_STORED
        |-> result.target_id == '0 && result.out_data == '0)
        else $error("stored result carries data");

    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without requests");

endmodule

bind blocking_fifo_with_waiter_queue bfwq_checker u_bfwq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

>>> test/tb_blocking_fifo_with_waiter_queue.sv
// ----------------------------------------------------------------------------
// tb_blocking_fifo_with_waiter_queue
// Self-checking bench for the blocking FIFO with waiter queue. A directed
// opening covers each request type, handoff to waiters and flush with and
// without waiters. A waiter overflow and an item store fill follow, then
// random request sequences, all sent in bursts with gaps. A behavioral
// mailbox model predicts every result, and the monitor compares each result
// field by field in order.
// ----------------------------------------------------------------------------
module tb_blocking_fifo_with_waiter_queue;
    import bfwq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 310;

    typedef struct {
        req_t req;
        bit   drain;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t request = '0;
    logic busy;
    logic result_valid;
    rsp_t result;

    stim_t stim_q[$];
    rsp_t due_results[$];

    logic [DATA_WIDTH-1:0] stored_items[$];
    logic [ID_WIDTH-1:0]   waiting_ids[$];
    logic [VISIT_W-1:0]    visits = '0;

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;

    blocking_fifo_with_waiter_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    always #6 clk = ~clk;

    function automatic req_t make_req(logic [1:0] t, logic [DATA_WIDTH-1:0] d,
                                      logic [ID_WIDTH-1:0] id);
        req_t r;
        r.req_type = t;
        r.elem_data = d;
        r.requester_id = id;
        return r;
    endfunction

    function automatic logic [ID_WIDTH-1:0] rand_id();
        return ID_WIDTH'($urandom_range(0, (1 << ID_WIDTH) - 1));
    endfunction

    function automatic logic [1:0] pick_op();
        int n;
        n = $urandom_range(0, 99);
        if (n < 40)
            return REQ_ENQ;
        else if (n < 65)
            return REQ_DEQ;
        else if (n < 95)
            return REQ_TRY;
        return REQ_FLUSH;
    endfunction

    task automatic add(logic [1:0] t, logic [DATA_WIDTH-1:0] d,
                       logic [ID_WIDTH-1:0] id, bit drain = 1'b0);
        stim_t s;
        s.req = make_req(t, d, id);
        s.drain = drain;
        stim_q.push_back(s);
    endtask

    task automatic add_overflow();
        // overfill the waiter queue, then release everyone
        add(REQ_FLUSH, $urandom(), rand_id());
        for (int i = 0; i < WAITER_DEPTH + 2; i++)
            add(REQ_DEQ, $urandom(), rand_id());
        add(($urandom_range(0, 1) == 0) ? REQ_FLUSH : REQ_ENQ, $urandom(), rand_id());
        add(REQ_FLUSH, $urandom(), rand_id());
    endtask

    task automatic mailbox_step(input req_t r);
        rsp_t e;
        bit   released;
        e = '0;
        e.last = 1'b1;
        released = 1'b0;
        case (r.req_type)
            REQ_ENQ:
            begin
                if (waiting_ids.size() > 0)
                begin
                    e.resp_kind = KIND_HANDED;
                    e.target_id = waiting_ids.pop_front();
                    e.out_data = r.elem_data;
                    visits++;
                end
                else if (stored_items.size() >= ITEM_DEPTH)
                    e.resp_kind = KIND_REJECTED;
                else
                begin
                    stored_items.push_back(r.elem_data);
                    e.resp_kind = KIND_STORED;
                end
            end
            REQ_DEQ, REQ_TRY:
            begin
                e.target_id = r.requester_id;
                if (stored_items.size() > 0)
                begin
                    e.resp_kind = KIND_DEQUEUED;
                    e.out_data = stored_items.pop_front();
                    visits++;
                end
                else if (r.req_type == REQ_TRY)
                    e.resp_kind = KIND_EMPTY;
                else if (waiting_ids.size() >= WAITER_DEPTH)
                    e.resp_kind = KIND_REJECTED;
                else
                begin
                    waiting_ids.push_back(r.requester_id);
                    e.resp_kind = KIND_WAITING;
                end
            end
            default:
            begin
                stored_items.delete();
                e.resp_kind = KIND_RELEASED;
                // release waiters oldest first, one result each
                while (waiting_ids.size() > 0)
                begin
                    e.target_id = waiting_ids.pop_front();
                    e.item_count = '0;
                    e.waiter_count = WAITER_CW'(waiting_ids.size());
                    e.visited_count = visits;
                    e.last = (waiting_ids.size() == 0);
                    due_results.push_back(e);
                    released = 1'b1;
                end
                if (released)
                    return;
            end
        endcase
        e.item_count = ITEM_CW'(stored_items.size());
        e.waiter_count = WAITER_CW'(waiting_ids.size());
        e.visited_count = visits;
        due_results.push_back(e);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                mailbox_step(request);
                void'(stim_q.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (start && busy)
            begin
                // hold the request until accepted
            end
            else if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (stim_q.size() == 0 || (stim_q[0].drain && due_results.size() != 0))
                start <= 1'b0;
            else if (burst_left == 0)
            begin
                start <= 1'b0;
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 10);
                gap_left = $urandom_range(0, 6);
            end
            else
            begin
                start <= 1'b1;
                request <= stim_q[0].req;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: kind %0d target %0d data %h",
                       result.resp_kind, result.target_id, result.out_data);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result.resp_kind !== want.resp_kind)
                begin
                    $error("resp_kind: expected %0d, got %0d", want.resp_kind,
                           result.resp_kind);
                    errors++;
                end
                if (result.target_id !== want.target_id)
                begin
                    $error("target_id: expected %0d, got %0d", want.target_id,
                           result.target_id);
                    errors++;
                end
                if (result.out_data !== want.out_data)
                begin
                    $error("out_data: expected %h, got %h", want.out_data, result.out_data);
                    errors++;
                end
                if (result.item_count !== want.item_count)
                begin
                    $error("item_count: expected %0d, got %0d", want.item_count,
                           result.item_count);
                    errors++;
                end
                if (result.waiter_count !== want.waiter_count)
                begin
                    $error("waiter_count: expected %0d, got %0d", want.waiter_count,
                           result.waiter_count);
                    errors++;
                end
                if (result.visited_count !== want.visited_count)
                begin
                    $error("visited_count: expected %0d, got %0d", want.visited_count,
                           result.visited_count);
                    errors++;
                end
                if (result.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, result.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** blocking_fifo_with_waiter_queue: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int kind;
        int n;
        int m;
        bit filled;
        bit overflowed;
        filled = 1'b0;
        overflowed = 1'b0;

        add(REQ_FLUSH, '0, '0);
        add(REQ_TRY, '0, '1);
        add(REQ_DEQ, '0, '0);
        add(REQ_DEQ, '0, '1);
        add(REQ_ENQ, '1, '0);
        add(REQ_ENQ, '0, '0);
        add(REQ_ENQ, 32'hA5A5_A5A5, 4'd7);
        add(REQ_TRY, '1, 4'd3);
        add(REQ_ENQ, 32'h5A5A_5A5A, '1);
        add(REQ_DEQ, '1, 4'd9);
        add(REQ_DEQ, '1, 4'd10);
        add(REQ_DEQ, '0, 4'd5);
        add(REQ_DEQ, '0, '1);
        add(REQ_FLUSH, '1, '1);
        add(REQ_ENQ, 32'h8000_0001, '0);
        add(REQ_ENQ, 32'h7FFF_FFFE, '0);
        add(REQ_FLUSH, '0, '0);
        add(REQ_TRY, '0, 4'd1);
        add(REQ_ENQ, '1, '1, 1'b1);
        sent = stim_q.size();

        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (!overflowed)
            begin
                add_overflow();
                overflowed = 1'b1;
            end
            else if (!filled)
            begin
                // fill the item store past its depth, then release it
                add(REQ_FLUSH, $urandom(), rand_id(), 1'b1);
                for (int i = 0; i < ITEM_DEPTH + 1; i++)
                    add(REQ_ENQ, $urandom(), rand_id());
                add(REQ_FLUSH, $urandom(), rand_id());
                filled = 1'b1;
            end
            else if (kind < 50)
            begin
                n = $urandom_range(5, 20);
                for (int i = 0; i < n; i++)
                    add(pick_op(), $urandom(), rand_id(),
                        i == 0 && $urandom_range(0, 9) == 0);
            end
            else if (kind < 75)
            begin
                // consumers wait, then producers hand items over
                n = $urandom_range(1, WAITER_DEPTH);
                for (int i = 0; i < n; i++)
                    add(REQ_DEQ, $urandom(), rand_id());
                m = $urandom_range(0, n + 2);
                for (int i = 0; i < m; i++)
                    add(REQ_ENQ, $urandom(), rand_id());
                if ($urandom_range(0, 2) == 0)
                    add(REQ_FLUSH, $urandom(), rand_id());
            end
            else if (kind < 88)
            begin
                add_overflow();
            end
            else
            begin
                n = $urandom_range(3, 10);
                for (int i = 0; i < n; i++)
                    add(2'($urandom_range(0, 3)), $urandom(), rand_id());
            end
            sent = stim_q.size();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_q.size() == 0 && due_results.size() == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && due_results.size() == 0)
            $display("** blocking_fifo_with_waiter_queue: PASSED **");
        else
            $display("** blocking_fifo_with_waiter_queue: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bfwq_pkg.sv
rtl/core/bfwq_ram.sv
rtl/core/bfwq_front.sv
rtl/core/bfwq_back.sv
rtl/core/blocking_fifo_with_waiter_queue.sv
rtl/core/bfwq_checker.sv
test/tb_blocking_fifo_with_waiter_queue.sv
